/* design/mbcc_pkg.sv */
// Shared types and constants of the multi-button click classifier.
package mbcc_pkg;

  // Width of the per-pin duration counters and their saturation value.
  localparam int unsigned CNT_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  // Largest number of button pins the block carries.
  localparam int unsigned MAX_PINS = 16;

  // Register map indexes (byte address divided by four).
  localparam logic [1:0] REG_SHORT_TICKS  = 2'd0;
  localparam logic [1:0] REG_LONG_TICKS   = 2'd1;
  localparam logic [1:0] REG_DOUBLE_WIN   = 2'd2;
  localparam logic [1:0] REG_ACTIVE_LOW   = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0]  SHORT_TICKS_RST = 8'd3;
  localparam logic [7:0]  LONG_TICKS_RST  = 8'd100;
  localparam logic [7:0]  DOUBLE_WIN_RST  = 8'd30;
  localparam logic [15:0] ACTIVE_LOW_RST  = 16'h0000;

  // Thresholds every lane compares against.
  typedef struct packed {
    logic [CNT_W-1:0] short_ticks;
    logic [CNT_W-1:0] long_ticks;
    logic [CNT_W-1:0] double_win;
  } click_cfg_t;

  // Click events found by one lane in one tick.
  typedef struct packed {
    logic shrt;
    logic lng;
    logic dbl;
  } pin_evt_t;

  // Event masks over all pins for one tick.
  typedef struct packed {
    logic [MAX_PINS-1:0] short_mask;
    logic [MAX_PINS-1:0] long_mask;
    logic [MAX_PINS-1:0] double_mask;
  } click_masks_t;

endpackage

/* design/mbcc_lane.sv */
// One pin lane: press and since-click counters and click classification.
module mbcc_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               pressed,
  input  mbcc_pkg::click_cfg_t cfg,
  output mbcc_pkg::pin_evt_t evt
);
  import mbcc_pkg::*;

  logic [CNT_W-1:0] press_r, press_nxt;
  logic [CNT_W-1:0] since_r, since_nxt;
  logic [CNT_W-1:0] since_inc;
  logic             is_long;
  logic             is_short;
  logic             is_dbl;

  // Press counter saturates while held and clears on release.
  always_comb begin
    if (pressed) begin
      press_nxt = (press_r == CNT_MAX) ? CNT_MAX : press_r + CNT_W'(1);
    end else begin
      press_nxt = '0;
    end
  end

  // Threshold compares; long wins when both thresholds match.
  always_comb begin
    is_long   = (press_nxt == cfg.long_ticks);
    is_short  = (press_nxt == cfg.short_ticks) && !is_long;
    since_inc = (since_r == CNT_MAX) ? CNT_MAX : since_r + CNT_W'(1);
    is_dbl    = is_short && (since_inc <= cfg.double_win);
    evt.lng   = is_long;
    evt.dbl   = is_dbl;
    evt.shrt  = is_short && !is_dbl;
    since_nxt = evt.shrt ? '0 : since_inc;
  end

  // Counters advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r <= '0;
      since_r <= CNT_MAX;
    end else if (adv) begin
      press_r <= press_nxt;
      since_r <= since_nxt;
    end
  end

endmodule

/* design/mbcc_merge.sv */
// Merge stage: drops empty ticks and queues results in a two-entry output buffer.
module mbcc_merge (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  mbcc_pkg::click_masks_t   masks,
  output logic                     push_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [15:0]              out_short_mask,
  output logic [15:0]              out_long_mask,
  output logic [15:0]              out_double_mask
);
  import mbcc_pkg::*;

  click_masks_t main_r, main_nxt;
  click_masks_t skid_r, skid_nxt;
  logic         main_vld_r, main_vld_nxt;
  logic         skid_vld_r, skid_vld_nxt;
  logic         hit;
  logic         wr;
  logic         rd;

  // A tick only produces a transaction when some pin fired.
  assign hit = |{masks.short_mask, masks.long_mask, masks.double_mask};
  assign wr  = push && hit;
  assign rd  = main_vld_r && out_ready;

  assign push_ready = !skid_vld_r;

  // Queue next-state: main is the head, skid holds the second entry.
  always_comb begin
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (rd) begin
      main_nxt     = skid_r;
      main_vld_nxt = skid_vld_r;
      skid_vld_nxt = 1'b0;
    end
    if (wr) begin
      if (!main_vld_nxt) begin
        main_nxt     = masks;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = masks;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  // Valid flags take reset; payload does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = main_vld_r;
  assign out_short_mask  = main_r.short_mask;
  assign out_long_mask   = main_r.long_mask;
  assign out_double_mask = main_r.double_mask;

endmodule

/* design/multi_button_click_classifier.sv */
// Top level of the multi-button click classifier: register port, pin lanes and merge.
//
// Usage: each input transaction (in_valid/in_ready, in_pin_levels) is one tick
// carrying the raw level of every button pin. Each pin has its own lane that
// tracks press duration and time since the last click, and reports short,
// long and double clicks. A result transaction (out_valid/out_ready and the
// three masks) is sent only for ticks where at least one mask bit is set.
// The result of an accepted tick is registered in the output buffer.
// Throughput: one tick per cycle while in_ready is high; the two-entry output
// buffer lets a new tick in while one result waits.
// Stall: if the receiver holds out_ready low, in_ready drops only once both
// output entries are full.
// Reset (synchronous, rst_n low): press counters clear, since-click counters
// go to 255, registers take their defaults and the output buffer empties.
// Registers are written over the APB-style port at byte addresses 0, 4, 8, 12
// and should be changed only while no tick is in flight.
module multi_button_click_classifier #(
  parameter int unsigned NUM_PINS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_pin_levels,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_short_mask,
  output logic [15:0] out_long_mask,
  output logic [15:0] out_double_mask,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mbcc_pkg::*;

  logic [7:0]   short_ticks_r;
  logic [7:0]   long_ticks_r;
  logic [7:0]   double_win_r;
  logic [15:0]  active_low_r;
  logic         cfg_wr;
  logic [1:0]   cfg_idx;
  logic         in_acc;
  logic         merge_ready;
  click_cfg_t   lane_cfg;
  pin_evt_t     evt [MAX_PINS];
  click_masks_t masks;

  // Register port: always ready, write on the access phase.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_ticks_r <= SHORT_TICKS_RST;
      long_ticks_r  <= LONG_TICKS_RST;
      double_win_r  <= DOUBLE_WIN_RST;
      active_low_r  <= ACTIVE_LOW_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SHORT_TICKS: short_ticks_r <= pwdata[7:0];
        REG_LONG_TICKS:  long_ticks_r  <= pwdata[7:0];
        REG_DOUBLE_WIN:  double_win_r  <= pwdata[7:0];
        REG_ACTIVE_LOW:  active_low_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (cfg_idx)
      REG_SHORT_TICKS: prdata = {24'd0, short_ticks_r};
      REG_LONG_TICKS:  prdata = {24'd0, long_ticks_r};
      REG_DOUBLE_WIN:  prdata = {24'd0, double_win_r};
      REG_ACTIVE_LOW:  prdata = {16'd0, active_low_r};
      default:         prdata = '0;
    endcase
  end

  assign lane_cfg.short_ticks = short_ticks_r;
  assign lane_cfg.long_ticks  = long_ticks_r;
  assign lane_cfg.double_win  = double_win_r;

  assign in_ready = merge_ready;
  assign in_acc   = in_valid && merge_ready;

  // One lane per populated pin; unused pins report nothing.
  for (genvar i = 0; i < MAX_PINS; i++) begin : g_pin
    if (i < NUM_PINS) begin : g_lane
      mbcc_lane u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (in_acc),
        .pressed (in_pin_levels[i] ^ active_low_r[i]),
        .cfg     (lane_cfg),
        .evt     (evt[i])
      );
    end else begin : g_unused
      assign evt[i] = '0;
    end
  end

  // Gather lane events into per-kind masks.
  always_comb begin
    for (int unsigned j = 0; j < MAX_PINS; j++) begin
      masks.short_mask[j]  = evt[j].shrt;
      masks.long_mask[j]   = evt[j].lng;
      masks.double_mask[j] = evt[j].dbl;
    end
  end

  mbcc_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (in_acc),
    .masks           (masks),
    .push_ready      (merge_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_short_mask  (out_short_mask),
    .out_long_mask   (out_long_mask),
    .out_double_mask (out_double_mask)
  );

endmodule
